// ===== rtl/core/b64d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, codes and the character classifier shared by the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_ZERO  = 8'h00;
   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   localparam logic [5:0] SEXTET_PLUS  = 6'd62;
   localparam logic [5:0] SEXTET_SLASH = 6'd63;

   localparam logic [5:0] LOW_NIBBLE_MASK = 6'h0F;
   localparam logic [5:0] LOW_PAIR_MASK   = 6'h03;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_MALFORMED = 2'd1,
      STATUS_EMPTY     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CLS_SEXTET = 2'd0,
      CLS_PAD    = 2'd1,
      CLS_ZERO   = 2'd2,
      CLS_OTHER  = 2'd3
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic [5:0]     sextet;
      logic           last;
   } cmd_type;

   function automatic cmd_type classify(input logic [7:0] c, input logic last);
      cmd_type r;
      r.cls    = CLS_OTHER;
      r.sextet = '0;
      r.last   = last;
      if (c inside {[8'h41:8'h5A]}) begin
         r.cls    = CLS_SEXTET;
         r.sextet = 6'(c - 8'h41);
      end else if (c inside {[8'h61:8'h7A]}) begin
         r.cls    = CLS_SEXTET;
         r.sextet = 6'(c - 8'h47);
      end else if (c inside {[8'h30:8'h39]}) begin
         r.cls    = CLS_SEXTET;
         r.sextet = 6'(c + 8'h04);
      end else if (c == CHAR_PLUS) begin
         r.cls    = CLS_SEXTET;
         r.sextet = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         r.cls    = CLS_SEXTET;
         r.sextet = SEXTET_SLASH;
      end else if (c == CHAR_PAD) begin
         r.cls = CLS_PAD;
      end else if (c == CHAR_ZERO) begin
         r.cls = CLS_ZERO;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/b64d_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_req_if / b64d_rsp_if
// Valid/ready channels for text items in and decoded items out.
// ----------------------------------------------------------------------------
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       last;

   modport source (output valid, output text_byte, output last, input ready);
   modport sink   (input valid, input text_byte, input last, output ready);
endinterface

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       end_of_message;
   logic [1:0] status;

   modport source (output valid, output out_byte, output byte_valid,
                   output end_of_message, output status, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input end_of_message, input status, output ready);
endinterface

// ===== rtl/core/b64d_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Accept text items, classify each byte and register the command.
// ----------------------------------------------------------------------------
module b64d_front (
   input  logic              clock,
   input  logic              reset,
   b64d_req_if.sink          req,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output b64d_pkg::cmd_type cmd
);

   logic              valid_ff;
   logic              valid_in;
   b64d_pkg::cmd_type cmd_ff;
   b64d_pkg::cmd_type cmd_in;
   logic              take;

   assign req.ready = !valid_ff || cmd_ready;
   assign take      = req.valid && req.ready;

   always_comb begin
      cmd_in   = cmd_ff;
      valid_in = valid_ff && !cmd_ready;
      if (take) begin
         cmd_in   = b64d_pkg::classify(req.text_byte, req.last);
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

// ===== rtl/core/b64d_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_queue
// Short command queue between classifier and decode back end.
// ----------------------------------------------------------------------------
module b64d_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  b64d_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output b64d_pkg::cmd_type pop_cmd
);

   b64d_pkg::cmd_type                  mem_ff [b64d_pkg::QUEUE_DEPTH];
   logic [b64d_pkg::QUEUE_AW-1:0]      wr_ptr_ff;
   logic [b64d_pkg::QUEUE_AW-1:0]      wr_ptr_in;
   logic [b64d_pkg::QUEUE_AW-1:0]      rd_ptr_ff;
   logic [b64d_pkg::QUEUE_AW-1:0]      rd_ptr_in;
   logic [b64d_pkg::QUEUE_CW-1:0]      count_ff;
   logic [b64d_pkg::QUEUE_CW-1:0]      count_in;
   logic                               push;
   logic                               pop;

   localparam logic [b64d_pkg::QUEUE_AW-1:0] LAST_PTR =
      b64d_pkg::QUEUE_AW'(b64d_pkg::QUEUE_DEPTH - 1);
   localparam logic [b64d_pkg::QUEUE_CW-1:0] FULL_COUNT =
      b64d_pkg::QUEUE_CW'(b64d_pkg::QUEUE_DEPTH);

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/b64d_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Merge sextets into bytes, track message state and drive the result register.
// ----------------------------------------------------------------------------
module b64d_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  b64d_pkg::cmd_type cmd,
   b64d_rsp_if.source        rsp
);

   logic [1:0]           phase_ff,  phase_in;
   logic [7:0]           partial_ff, partial_in;
   logic                 err_ff,    err_in;
   logic                 term_ff,   term_in;
   logic                 any_ff,    any_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           out_byte_ff,  out_byte_in;
   logic                 byte_valid_ff, byte_valid_in;
   logic                 eom_ff,       eom_in;
   b64d_pkg::status_type status_ff,    status_in;

   logic                 take;
   logic                 have_byte;
   logic [7:0]           byte_val;
   logic [7:0]           partial_nx;
   logic [1:0]           phase_nx;
   logic                 err_nx;
   logic                 term_nx;
   logic                 any_nx;

   assign cmd_ready = !rsp_valid_ff || rsp.ready;
   assign take      = cmd_valid && cmd_ready;

   always_comb begin
      have_byte  = 1'b0;
      byte_val   = '0;
      partial_nx = partial_ff;
      phase_nx   = phase_ff;
      err_nx     = err_ff;
      term_nx    = term_ff;
      if (!term_ff) begin
         case (cmd.cls)
            b64d_pkg::CLS_ZERO: begin
               term_nx = 1'b1;
            end
            b64d_pkg::CLS_PAD: begin
               if (phase_ff == 2'd1) begin
                  err_nx = 1'b1;
               end
            end
            b64d_pkg::CLS_SEXTET: begin
               if (!err_ff) begin
                  phase_nx = phase_ff + 2'd1;
                  case (phase_ff)
                     2'd0: begin
                        partial_nx = {cmd.sextet, 2'b00};
                     end
                     2'd1: begin
                        have_byte  = 1'b1;
                        byte_val   = partial_ff | {6'b0, cmd.sextet[5:4]};
                        partial_nx = {cmd.sextet[3:0] & b64d_pkg::LOW_NIBBLE_MASK[3:0],
                                      4'b0000};
                     end
                     2'd2: begin
                        have_byte  = 1'b1;
                        byte_val   = partial_ff | {4'b0, cmd.sextet[5:2]};
                        partial_nx = {cmd.sextet[1:0] & b64d_pkg::LOW_PAIR_MASK[1:0],
                                      6'b000000};
                     end
                     default: begin
                        have_byte  = 1'b1;
                        byte_val   = partial_ff | {2'b0, cmd.sextet};
                        partial_nx = '0;
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
      any_nx = any_ff || have_byte;
   end

   always_comb begin
      phase_in      = phase_ff;
      partial_in    = partial_ff;
      err_in        = err_ff;
      term_in       = term_ff;
      any_in        = any_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      eom_in        = eom_ff;
      status_in     = status_ff;
      if (take) begin
         if (cmd.last) begin
            phase_in   = '0;
            partial_in = '0;
            err_in     = 1'b0;
            term_in    = 1'b0;
            any_in     = 1'b0;
         end else begin
            phase_in   = phase_nx;
            partial_in = partial_nx;
            err_in     = err_nx;
            term_in    = term_nx;
            any_in     = any_nx;
         end
         if (have_byte || cmd.last) begin
            rsp_valid_in  = 1'b1;
            out_byte_in   = have_byte ? byte_val : 8'h00;
            byte_valid_in = have_byte;
            eom_in        = cmd.last;
            if (!cmd.last) begin
               status_in = b64d_pkg::STATUS_OK;
            end else if (err_nx) begin
               status_in = b64d_pkg::STATUS_MALFORMED;
            end else if (!any_nx) begin
               status_in = b64d_pkg::STATUS_EMPTY;
            end else begin
               status_in = b64d_pkg::STATUS_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         partial_ff   <= '0;
         err_ff       <= 1'b0;
         term_ff      <= 1'b0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         partial_ff   <= partial_in;
         err_ff       <= err_in;
         term_ff      <= term_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      eom_ff        <= eom_in;
      status_ff     <= status_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.out_byte       = out_byte_ff;
   assign rsp.byte_valid     = byte_valid_ff;
   assign rsp.end_of_message = eom_ff;
   assign rsp.status         = status_ff;

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !eom_ff |-> status_ff == b64d_pkg::STATUS_OK)
      else $error("status set on a result that does not end the message");

   a_result_has_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> byte_valid_ff || eom_ff)
      else $error("result item carries neither byte nor end flag");

   a_empty_without_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == b64d_pkg::STATUS_EMPTY |-> !byte_valid_ff)
      else $error("empty status together with a decoded byte");

   a_state_cleared_at_end: assert property (@(posedge clock) disable iff (reset)
      take && cmd.last |=> phase_ff == 2'd0 && !err_ff && !term_ff && !any_ff)
      else $error("message state not cleared after last item");

endmodule

// ===== rtl/core/base64_stream_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Lenient streaming base64 decoder: one text byte in, at most one byte out.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// req_chan  in   text_byte[7:0], last
// rsp_chan  out  out_byte[7:0], byte_valid, end_of_message, status[1:0]
//
// One item per cycle sustained while rsp_chan is not stalled; the decode back end handles one command a cycle.
// A text item passes through the classify register, the command queue and the
// result register in that order before its result, if any, reaches rsp_chan.
// Synchronous reset clears the message state and empties the queue.
// A stalled rsp_chan fills the queue and then lowers req_chan.ready.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core (
   input  logic      clock,
   input  logic      reset,
   b64d_req_if.sink  req_chan,
   b64d_rsp_if.source rsp_chan
);

   logic              front_valid;
   logic              front_ready;
   b64d_pkg::cmd_type front_cmd;
   logic              back_valid;
   logic              back_ready;
   b64d_pkg::cmd_type back_cmd;

   b64d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (back_cmd)
   );

   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .rsp       (rsp_chan)
   );

endmodule
